// File: hdl/fpst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared widths, command codes and the node store control beat.
// ----------------------------------------------------------------------------
package fpst_pkg;

  localparam int SUM_W        = 48;
  localparam int INDEX_W      = 10;
  localparam int AMOUNT_W     = 32;
  localparam int SIZE_DEFAULT = 1024;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic rd;
    logic wr;
  } store_ctl_t;

endpackage
`default_nettype wire

// File: hdl/fenwick_prefix_sum_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_top
// Binary indexed tree of SIZE signed 48-bit counters with add and prefix
// sum commands, walked one node per cycle through a shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Drive command, index and amount with start high; the beat is taken at
//   the edge where start is high and busy is low. An add (command 0) adds
//   amount at index and gives no result; an index at or beyond SIZE is
//   dropped. A query (command 1) returns the prefix sum of elements 0..index
//   (index clamped to SIZE-1) on prefix_sum, with done high for one cycle.
//   The receiver cannot stall: sample prefix_sum while done is high.
// Walk:
//   An item visits n tree nodes, one node read per cycle from the single
//   read port of the node memory, the data handled in the next cycle by
//   the one adder. busy stays high for the whole walk, and done rises at
//   the edge at which busy falls, so a new beat can be taken while done is
//   high. n is at most log2(SIZE) + 1; an add that is dropped visits no node.
// Reset:
//   rst is synchronous. After it a sweep zeroes every node, one per cycle,
//   holding busy high until the sweep ends.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_top #(
  parameter int SIZE = fpst_pkg::SIZE_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 command,
  input  wire         [fpst_pkg::INDEX_W-1:0] index,
  input  wire  signed [fpst_pkg::AMOUNT_W-1:0] amount,
  output logic                                done,
  output logic signed [fpst_pkg::SUM_W-1:0]   prefix_sum
);

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int PW = ((AW > fpst_pkg::INDEX_W) ? AW : fpst_pkg::INDEX_W) + 1;
  localparam logic [PW-1:0] SIZE_P = PW'(SIZE);
  localparam logic [PW-1:0] LAST_P = PW'(SIZE - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                        state;
  logic                        walking;
  logic                        pend;
  logic                        cmd;
  logic [PW-1:0]               pos;
  logic [AW-1:0]               pos_d;
  logic [fpst_pkg::SUM_W-1:0]  acc;
  logic [fpst_pkg::SUM_W-1:0]  delta;

  logic                        accept;
  logic                        clearing;
  logic [PW-1:0]               index_ext;
  logic [PW-1:0]               pos_inc;
  logic [PW-1:0]               up_next;
  logic [PW-1:0]               low;
  logic [PW-1:0]               down_next;
  logic                        walk_more;
  logic [fpst_pkg::SUM_W-1:0]  rdata;
  logic [fpst_pkg::SUM_W-1:0]  sum;
  fpst_pkg::store_ctl_t        ctl;

  assign busy      = (state != ST_IDLE) || clearing;
  assign accept    = start && !busy;
  assign index_ext = PW'(index);

  // Upward walk for adds, downward walk for queries
  assign pos_inc   = pos + 1'b1;
  assign up_next   = pos | pos_inc;
  assign low       = pos & pos_inc;
  assign down_next = low - 1'b1;
  assign walk_more = (cmd == fpst_pkg::CMD_QUERY) ? (low != '0) : (up_next < SIZE_P);

  // Shared adder: node update for adds, running total for queries
  assign sum = ((cmd == fpst_pkg::CMD_QUERY) ? acc : delta) + rdata;

  assign ctl.rd = (state == ST_WALK) && walking;
  assign ctl.wr = (state == ST_WALK) && pend && (cmd == fpst_pkg::CMD_ADD);

  fpst_node_store #(
    .SIZE (SIZE),
    .AW   (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .raddr    (pos[AW-1:0]),
    .waddr    (pos_d),
    .wdata    (sum),
    .rdata    (rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      walking <= 1'b0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (accept) begin
            cmd   <= command;
            delta <= {{(fpst_pkg::SUM_W - fpst_pkg::AMOUNT_W){amount[fpst_pkg::AMOUNT_W-1]}},
                      amount};
            acc   <= '0;
            pend  <= 1'b0;
            state <= ST_WALK;
            if (command == fpst_pkg::CMD_QUERY) begin
              pos     <= (index_ext > LAST_P) ? LAST_P : index_ext;
              walking <= 1'b1;
            end else begin
              pos     <= index_ext;
              walking <= (index_ext < SIZE_P);
            end
          end
        end
        ST_WALK: begin
          done <= !walking && pend && (cmd == fpst_pkg::CMD_QUERY);
          // issue the next node read while the previous node's data is used
          if (walking) begin
            pos     <= (cmd == fpst_pkg::CMD_QUERY) ? down_next : up_next;
            walking <= walk_more;
            pos_d   <= pos[AW-1:0];
            pend    <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && (cmd == fpst_pkg::CMD_QUERY)) begin
            acc <= sum;
          end
          if (!walking) begin
            state <= ST_IDLE;
            if (pend && (cmd == fpst_pkg::CMD_QUERY)) begin
              prefix_sum <= sum;
            end
          end
        end
      endcase
    end
  end

  a_done_after_walk : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_WALK) && (state == ST_IDLE))
    else $error("result beat without a finished walk");

  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !walking && !pend)
    else $error("walk still active while idle");

  a_no_write_in_clear : assert property (@(posedge clk) disable iff (rst)
    ctl.wr |-> !clearing && (cmd == fpst_pkg::CMD_ADD))
    else $error("node write during clear sweep or query");

  a_clear_holds_busy : assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy && !done)
    else $error("block available during clear sweep");

endmodule
`default_nettype wire

// File: hdl/fpst_node_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpst_node_store
// Tree node memory: one registered read port, one write port, and a
// zeroing sweep over every node after reset.
// ----------------------------------------------------------------------------
module fpst_node_store #(
  parameter int SIZE = fpst_pkg::SIZE_DEFAULT,
  parameter int AW   = $clog2(SIZE)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  fpst_pkg::store_ctl_t         ctl,
  input  wire  [AW-1:0]                raddr,
  input  wire  [AW-1:0]                waddr,
  input  wire  [fpst_pkg::SUM_W-1:0]   wdata,
  output logic [fpst_pkg::SUM_W-1:0]   rdata,
  output logic                         clearing
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);

  logic [fpst_pkg::SUM_W-1:0] mem [SIZE];
  logic [AW-1:0]              clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: verif/fpst_sum_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpst_sum_checker
// Watches the command and result ports of the prefix sum table, keeps its own
// binary indexed tree of 48-bit counters and compares every returned sum with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module fpst_sum_checker #(
  parameter int SIZE = fpst_pkg::SIZE_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire                                  busy,
  input  wire                                  command,
  input  wire         [fpst_pkg::INDEX_W-1:0]  index,
  input  wire  signed [fpst_pkg::AMOUNT_W-1:0] amount,
  input  wire                                  done,
  input  wire  signed [fpst_pkg::SUM_W-1:0]    prefix_sum,
  output int                                   failures,
  output int                                   sums_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [fpst_pkg::SUM_W-1:0] nodes [SIZE];
  logic [fpst_pkg::SUM_W-1:0] sums_due [$];

  function automatic void tree_add_amount(int unsigned pos,
                                          logic signed [fpst_pkg::AMOUNT_W-1:0] amt);
    logic [fpst_pkg::SUM_W-1:0] delta;
    delta = {{(fpst_pkg::SUM_W - fpst_pkg::AMOUNT_W){amt[fpst_pkg::AMOUNT_W-1]}}, amt};
    // adds at or beyond the table fall straight through
    while (pos < SIZE) begin
      nodes[pos] = nodes[pos] + delta;
      pos = pos | (pos + 1);
    end
  endfunction

  function automatic logic [fpst_pkg::SUM_W-1:0] tree_prefix_sum(int unsigned pos);
    logic [fpst_pkg::SUM_W-1:0] acc;
    int unsigned                low;
    bit                         walking;
    acc     = '0;
    walking = 1'b1;
    if (pos >= SIZE) pos = SIZE - 1;
    while (walking) begin
      acc = acc + nodes[pos];
      low = pos & (pos + 1);
      if (low == 0) walking = 1'b0;
      else pos = low - 1;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    logic [fpst_pkg::SUM_W-1:0] due;
    if (rst) begin
      foreach (nodes[i]) nodes[i] = '0;
      sums_due.delete();
      failures <= 0;
    end else begin
      // retire the result first: a beat taken at this edge cannot own it
      if (done) begin
        if (sums_due.size() == 0) begin
          $error("prefix_sum: no sum expected, got %0d", prefix_sum);
          failures <= failures + 1;
        end else begin
          due = sums_due.pop_front();
          if (prefix_sum !== due) begin
            $error("prefix_sum: expected %0d, got %0d", $signed(due), prefix_sum);
            failures <= failures + 1;
          end
        end
      end
      if (start && !busy) begin
        if (command == fpst_pkg::CMD_QUERY) sums_due.push_back(tree_prefix_sum(index));
        else tree_add_amount(index, amount);
      end
    end
    sums_waiting <= sums_due.size();
  end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Drives add and query commands into the prefix sum table with random gaps,
// a back-to-back burst of adds at the top node, and random traffic;
// the checker beside the block predicts and compares every sum.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_BEATS = 750;
  localparam int          BURST_BEATS  = 24;
  localparam int          SETTLE       = 20;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  localparam logic signed [fpst_pkg::AMOUNT_W-1:0] AMT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [fpst_pkg::AMOUNT_W-1:0] AMT_MIN = 32'sh8000_0000;
  localparam logic        [fpst_pkg::INDEX_W-1:0]  IDX_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = fpst_pkg::CMD_ADD;
  logic [fpst_pkg::INDEX_W-1:0] index = '0;
  logic signed [fpst_pkg::AMOUNT_W-1:0] amount = '0;
  wire busy;
  wire done;
  wire signed [fpst_pkg::SUM_W-1:0] prefix_sum;
  int failures;
  int sums_waiting;
  int unsigned cycles = 0;
  bit sender_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fenwick_prefix_sum_table_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .index      (index),
    .amount     (amount),
    .done       (done),
    .prefix_sum (prefix_sum)
  );

  fpst_sum_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .index        (index),
    .amount       (amount),
    .done         (done),
    .prefix_sum   (prefix_sum),
    .failures     (failures),
    .sums_waiting (sums_waiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** fenwick_prefix_sum_table_top: FAILED **");
      $finish;
    end
  end

  task automatic issue_beat(input logic cmd, input logic [fpst_pkg::INDEX_W-1:0] idx,
                            input logic signed [fpst_pkg::AMOUNT_W-1:0] amt);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    index   <= idx;
    amount  <= amt;
    // the beat goes at the first edge that finds busy low
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sums_waiting != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic                                 cmd;
    logic [fpst_pkg::INDEX_W-1:0]         idx;
    logic signed [fpst_pkg::AMOUNT_W-1:0] amt;
    logic [31:0]                          rnd;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, both ends of the index range and the amount extremes
    issue_beat(fpst_pkg::CMD_QUERY, '0, '0);
    issue_beat(fpst_pkg::CMD_QUERY, IDX_TOP, AMT_MAX);
    issue_beat(fpst_pkg::CMD_ADD, '0, AMT_MAX);
    issue_beat(fpst_pkg::CMD_ADD, IDX_TOP, AMT_MIN);
    issue_beat(fpst_pkg::CMD_ADD, 10'd512, -32'sd1);
    issue_beat(fpst_pkg::CMD_ADD, 10'd511, 32'sd1);
    issue_beat(fpst_pkg::CMD_QUERY, '0, '0);
    issue_beat(fpst_pkg::CMD_QUERY, 10'd511, '0);
    issue_beat(fpst_pkg::CMD_QUERY, 10'd512, AMT_MIN);
    issue_beat(fpst_pkg::CMD_QUERY, IDX_TOP, '0);
    issue_beat(fpst_pkg::CMD_ADD, 10'd1022, '0);
    issue_beat(fpst_pkg::CMD_ADD, 10'h155, 32'sh5555_5555);
    issue_beat(fpst_pkg::CMD_ADD, 10'h2AA, 32'shAAAA_AAAA);
    issue_beat(fpst_pkg::CMD_QUERY, 10'd1022, '0);
    issue_beat(fpst_pkg::CMD_QUERY, 10'h155, '0);
    issue_beat(fpst_pkg::CMD_QUERY, 10'h2AA, '0);
    hold_until_drained();

    // back-to-back adds at the top node, then read the totals back
    sender_calm = 1'b1;
    repeat (BURST_BEATS) issue_beat(fpst_pkg::CMD_ADD, IDX_TOP, AMT_MAX);
    issue_beat(fpst_pkg::CMD_QUERY, IDX_TOP, '0);
    issue_beat(fpst_pkg::CMD_QUERY, 10'd1022, '0);
    issue_beat(fpst_pkg::CMD_ADD, 10'd0, AMT_MIN);
    issue_beat(fpst_pkg::CMD_QUERY, IDX_TOP, '0);
    hold_until_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      cmd = $urandom_range(0, 1) ? fpst_pkg::CMD_QUERY : fpst_pkg::CMD_ADD;
      rnd = $urandom;
      case ($urandom_range(0, 7))
        0:       idx = '0;
        1:       idx = IDX_TOP;
        default: idx = rnd[fpst_pkg::INDEX_W-1:0];
      endcase
      case ($urandom_range(0, 9))
        0:       amt = AMT_MAX;
        1:       amt = AMT_MIN;
        2:       amt = -32'sd1;
        3:       amt = '0;
        default: amt = $urandom;
      endcase
      issue_beat(cmd, idx, amt);
      if ($urandom_range(0, 39) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("** fenwick_prefix_sum_table_top: PASSED **");
    end else begin
      $display("** fenwick_prefix_sum_table_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
